[rtl/mfd_pkg.sv]
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants for the message frame decoder.
// ----------------------------------------------------------------------------
package mfd_pkg;

   localparam int ENTRY_LIMIT = 32;
   localparam int CNT_W       = $clog2(ENTRY_LIMIT + 2);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] TYPE_MASK = 8'b0111_1111;
   localparam logic [7:0] ZERO_FLAG = 8'b1000_0000;

   typedef enum logic [1:0] {
      ST_ENTRY    = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_SHORT    = 2'd2,
      ST_OVER     = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  msg_id;
      logic [7:0]  sender;
      logic [4:0]  entry_index;
      logic [6:0]  entry_type;
      logic [31:0] payload;
      logic        last_entry;
      logic        count_err;
   } cmd_type;

endpackage

[rtl/mfd_front.sv]
// ----------------------------------------------------------------------------
// mfd_front
// Byte parser: walks the frame header and entries, pushes one command per
// completed entry or status event.
// ----------------------------------------------------------------------------
module mfd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   output logic             byte_ready,
   input  logic [7:0]       rx_byte,
   input  logic             frame_end,
   output logic             push,
   output mfd_pkg::cmd_type push_cmd,
   input  logic             queue_full
);
   import mfd_pkg::*;

   typedef enum logic [2:0] {
      PH_ID, PH_SENDER, PH_COUNT, PH_ENTRY, PH_PAYLOAD, PH_SKIP
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       id_ff, id_in;
   logic [7:0]       sender_ff, sender_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] done_ff, done_in;
   logic [6:0]       type_ff, type_in;
   logic [31:0]      acc_ff, acc_in;
   logic [1:0]       seen_ff, seen_in;

   logic             accept;
   logic             emit;
   cmd_type          cmd;
   logic             last;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;
   assign push       = accept && emit;
   assign push_cmd   = cmd;
   assign last       = (done_ff + 1'b1) >= total_ff;

   always_comb begin
      phase_in  = phase_ff;
      id_in     = id_ff;
      sender_in = sender_ff;
      total_in  = total_ff;
      done_in   = done_ff;
      type_in   = type_ff;
      acc_in    = acc_ff;
      seen_in   = seen_ff;
      emit      = 1'b0;
      cmd       = '0;
      case (phase_ff)
         PH_ID: begin
            id_in     = rx_byte;
            sender_in = '0;
            total_in  = '0;
            done_in   = '0;
            phase_in  = PH_SENDER;
            if (frame_end) begin
               emit          = 1'b1;
               cmd.status    = ST_SHORT;
               cmd.count_err = 1'b1;
               phase_in      = PH_ID;
            end
         end
         PH_SENDER: begin
            sender_in = rx_byte;
            phase_in  = PH_COUNT;
            if (frame_end) begin
               emit          = 1'b1;
               cmd.status    = ST_SHORT;
               cmd.count_err = 1'b1;
               phase_in      = PH_ID;
            end
         end
         PH_COUNT: begin
            total_in = rx_byte[CNT_W-1:0];
            done_in  = '0;
            if (rx_byte == 8'd0) begin
               emit       = 1'b1;
               cmd.status = ST_EMPTY;
               phase_in   = frame_end ? PH_ID : PH_SKIP;
            end else if (rx_byte > 8'(ENTRY_LIMIT)) begin
               emit          = 1'b1;
               cmd.status    = ST_OVER;
               cmd.count_err = 1'b1;
               phase_in      = frame_end ? PH_ID : PH_SKIP;
            end else if (frame_end) begin
               emit          = 1'b1;
               cmd.status    = ST_SHORT;
               cmd.count_err = 1'b1;
               phase_in      = PH_ID;
            end else begin
               phase_in = PH_ENTRY;
            end
         end
         PH_ENTRY: begin
            type_in  = rx_byte[6:0] & TYPE_MASK[6:0];
            acc_in   = '0;
            seen_in  = '0;
            phase_in = PH_PAYLOAD;
            if ((rx_byte & ZERO_FLAG) != 8'd0) begin
               emit = 1'b1;
            end else if (frame_end) begin
               emit          = 1'b1;
               cmd.status    = ST_SHORT;
               cmd.count_err = 1'b1;
               phase_in      = PH_ID;
            end
         end
         PH_PAYLOAD: begin
            case (seen_ff)
               2'd0:    acc_in[7:0]   = rx_byte;
               2'd1:    acc_in[15:8]  = rx_byte;
               2'd2:    acc_in[23:16] = rx_byte;
               default: acc_in[31:24] = rx_byte;
            endcase
            seen_in = seen_ff + 2'd1;
            if (seen_ff == 2'd3) begin
               emit = 1'b1;
            end else if (frame_end) begin
               emit          = 1'b1;
               cmd.status    = ST_SHORT;
               cmd.count_err = 1'b1;
               phase_in      = PH_ID;
            end
         end
         default: begin
            phase_in = frame_end ? PH_ID : PH_SKIP;
         end
      endcase

      // complete an entry: zero-flag entry byte or fourth payload byte
      if (emit && (phase_in == PH_PAYLOAD || (phase_ff == PH_PAYLOAD && seen_ff == 2'd3))) begin
         done_in = done_ff + 1'b1;
         if (!last && frame_end) begin
            cmd.status    = ST_SHORT;
            cmd.count_err = 1'b1;
            phase_in      = PH_ID;
         end else begin
            cmd.status      = ST_ENTRY;
            cmd.entry_index = done_ff[4:0];
            cmd.entry_type  = (phase_ff == PH_ENTRY) ? type_in : type_ff;
            cmd.payload     = (phase_ff == PH_ENTRY) ? 32'd0 : acc_in;
            cmd.last_entry  = last;
            phase_in        = last ? (frame_end ? PH_ID : PH_SKIP) : PH_ENTRY;
         end
      end
      cmd.msg_id = id_in;
      cmd.sender = sender_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_ID;
         id_ff     <= '0;
         sender_ff <= '0;
         total_ff  <= '0;
         done_ff   <= '0;
         type_ff   <= '0;
         acc_ff    <= '0;
         seen_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         id_ff     <= id_in;
         sender_ff <= sender_in;
         total_ff  <= total_in;
         done_ff   <= done_in;
         type_ff   <= type_in;
         acc_ff    <= acc_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

[rtl/mfd_queue.sv]
// ----------------------------------------------------------------------------
// mfd_queue
// Short command queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module mfd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mfd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output mfd_pkg::cmd_type pop_cmd
);
   import mfd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ff, wr_in;
   logic [PTR_W-1:0]       rd_ff, rd_in;
   logic [PTR_W:0]         count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full      = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_cmd   = entry_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/mfd_back.sv]
// ----------------------------------------------------------------------------
// mfd_back
// Result stage: keeps the saturating error count and holds the output
// register of the result channel.
// ----------------------------------------------------------------------------
module mfd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  mfd_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [79:0]      rsp_tdata,
   output logic             rsp_tlast
);
   import mfd_pkg::*;

   logic          valid_ff, valid_in;
   logic [15:0]   err_ff, err_in;
   cmd_type       out_ff;

   assign cmd_pop    = cmd_valid && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = out_ff.last_entry;
   assign rsp_tdata  = {2'b00, err_ff, out_ff.payload, out_ff.entry_type,
                        out_ff.entry_index, out_ff.sender, out_ff.msg_id,
                        out_ff.status};

   always_comb begin
      err_in   = err_ff;
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd_pop) begin
         valid_in = 1'b1;
         if (cmd.count_err && err_ff != 16'hFFFF) begin
            err_in = err_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         out_ff <= cmd;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         err_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         err_ff   <= err_in;
      end
   end

endmodule

[rtl/message_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// message_frame_decoder_unit
// Decodes a byte stream of message frames into entry and status results.
//
// The req_ channel carries one frame byte per transfer, frame end on tlast.
// The rsp_ channel carries one result per completed entry or status event;
// tlast marks the final entry of a message. Bytes that complete nothing
// give no transfer.
// A new byte is taken every cycle while the queue is not full. A result is
// written by the parser into a two-entry queue, then into the output
// register. When the receiver stalls the queue fills and req_tready drops
// once both entries and the output register hold results.
// Reset clears the parser to expect an id byte, empties the queue and the
// output register and zeroes the error count.
// ----------------------------------------------------------------------------
module message_frame_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // status, msg_id, sender, entry_index,
                                    // entry_type, payload, error_total, zero pad
   output logic        rsp_tlast    // last_entry
);
   import mfd_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    full;
   logic    pop;
   logic    not_empty;
   cmd_type pop_cmd;

   mfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .rx_byte    (req_tdata),
      .frame_end  (req_tlast),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (full)
   );

   mfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_cmd   (pop_cmd)
   );

   mfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (not_empty),
      .cmd        (pop_cmd),
      .cmd_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[tb/sv/mfd_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mfd_result_checker
// Watches both streams of the message frame decoder. Each accepted frame
// byte runs through a local frame parser that tracks header, entries,
// payload and the saturating error count, and any result it produces is
// queued. Each result transfer is checked field by field against the oldest
// queued result; unexpected results and field mismatches are counted.
// ----------------------------------------------------------------------------
module mfd_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tlast,   // frame_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,   // status, msg_id, sender, entry_index,
                                    // entry_type, payload, error_total, zero pad
   input  logic        rsp_tlast,   // last_entry
   output int          fail_count,
   output int          results_owed
);
   import mfd_pkg::*;

   typedef enum logic [2:0] {
      PH_ID,
      PH_SENDER,
      PH_COUNT,
      PH_ENTRY,
      PH_PAYLOAD,
      PH_SKIP
   } parse_phase_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  msg_id;
      logic [7:0]  sender;
      logic [4:0]  entry_index;
      logic [6:0]  entry_type;
      logic [31:0] payload;
      logic        last_entry;
      logic [15:0] error_total;
   } frame_result_type;

   parse_phase_type  phase;
   logic [7:0]       hdr_id;
   logic [7:0]       hdr_sender;
   logic [7:0]       entry_count;
   logic [7:0]       entries_seen;
   logic [6:0]       cur_type;
   logic [31:0]      pay_acc;
   logic [1:0]       pay_bytes;
   logic [15:0]      err_count;

   frame_result_type awaited_results[$];
   frame_result_type predicted;
   frame_result_type observed;
   frame_result_type wanted;
   bit               emit_now;

   initial fail_count = 0;
   initial results_owed = 0;

   function automatic frame_result_type status_result(status_type st);
      frame_result_type r;
      r = '0;
      r.status      = st;
      r.msg_id      = hdr_id;
      r.sender      = hdr_sender;
      r.error_total = err_count;
      return r;
   endfunction

   task automatic take_short_frame(output frame_result_type r);
      if (err_count != 16'hFFFF) begin
         err_count++;
      end
      phase = PH_ID;
      r = status_result(ST_SHORT);
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic fend,
                              output bit emit, output frame_result_type r);
      bit         done_entry;
      bit         last;
      logic [7:0] idx;
      emit       = 1'b0;
      done_entry = 1'b0;
      r          = '0;
      case (phase)
         PH_ID: begin
            hdr_id       = b;
            hdr_sender   = '0;
            entry_count  = '0;
            entries_seen = '0;
            if (fend) begin
               emit = 1'b1;
               take_short_frame(r);
            end else begin
               phase = PH_SENDER;
            end
         end
         PH_SENDER: begin
            hdr_sender = b;
            if (fend) begin
               emit = 1'b1;
               take_short_frame(r);
            end else begin
               phase = PH_COUNT;
            end
         end
         PH_COUNT: begin
            entry_count  = b;
            entries_seen = '0;
            if (b == 8'd0) begin
               phase = fend ? PH_ID : PH_SKIP;
               emit  = 1'b1;
               r     = status_result(ST_EMPTY);
            end else if (int'(b) > ENTRY_LIMIT) begin
               if (err_count != 16'hFFFF) begin
                  err_count++;
               end
               phase = fend ? PH_ID : PH_SKIP;
               emit  = 1'b1;
               r     = status_result(ST_OVER);
            end else if (fend) begin
               emit = 1'b1;
               take_short_frame(r);
            end else begin
               phase = PH_ENTRY;
            end
         end
         PH_ENTRY: begin
            cur_type  = b[6:0];
            pay_acc   = '0;
            pay_bytes = '0;
            if ((b & ZERO_FLAG) != 8'd0) begin
               done_entry = 1'b1;
            end else if (fend) begin
               emit = 1'b1;
               take_short_frame(r);
            end else begin
               phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            pay_acc = pay_acc | (32'(b) << (int'(pay_bytes) * 8));
            if (pay_bytes == 2'd3) begin
               pay_bytes  = '0;
               done_entry = 1'b1;
            end else begin
               pay_bytes++;
               if (fend) begin
                  emit = 1'b1;
                  take_short_frame(r);
               end
            end
         end
         default: begin
            phase = fend ? PH_ID : PH_SKIP;
         end
      endcase

      if (done_entry) begin
         idx          = entries_seen;
         last         = (int'(idx) + 1) >= int'(entry_count);
         entries_seen = idx + 8'd1;
         emit         = 1'b1;
         if (!last && fend) begin
            take_short_frame(r);
         end else begin
            if (last) begin
               phase = fend ? PH_ID : PH_SKIP;
            end else begin
               phase = PH_ENTRY;
            end
            r.status      = ST_ENTRY;
            r.msg_id      = hdr_id;
            r.sender      = hdr_sender;
            r.entry_index = idx[4:0];
            r.entry_type  = cur_type;
            r.payload     = pay_acc;
            r.last_entry  = last;
            r.error_total = err_count;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase        = PH_ID;
         hdr_id       = '0;
         hdr_sender   = '0;
         entry_count  = '0;
         entries_seen = '0;
         cur_type     = '0;
         pay_acc      = '0;
         pay_bytes    = '0;
         err_count    = '0;
         awaited_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            observed.status      = status_type'(rsp_tdata[1:0]);
            observed.msg_id      = rsp_tdata[9:2];
            observed.sender      = rsp_tdata[17:10];
            observed.entry_index = rsp_tdata[22:18];
            observed.entry_type  = rsp_tdata[29:23];
            observed.payload     = rsp_tdata[61:30];
            observed.error_total = rsp_tdata[77:62];
            observed.last_entry  = rsp_tlast;
            if (awaited_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual %h",
                        $time, observed);
            end else begin
               wanted = awaited_results.pop_front();
               check_field("status", 32'(wanted.status), 32'(observed.status));
               check_field("msg_id", 32'(wanted.msg_id), 32'(observed.msg_id));
               check_field("sender", 32'(wanted.sender), 32'(observed.sender));
               check_field("entry_index", 32'(wanted.entry_index),
                           32'(observed.entry_index));
               check_field("entry_type", 32'(wanted.entry_type),
                           32'(observed.entry_type));
               check_field("payload", wanted.payload, observed.payload);
               check_field("last_entry", 32'(wanted.last_entry),
                           32'(observed.last_entry));
               check_field("error_total", 32'(wanted.error_total),
                           32'(observed.error_total));
            end
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast, emit_now, predicted);
            if (emit_now) begin
               awaited_results.push_back(predicted);
            end
         end
      end
      results_owed <= awaited_results.size();
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the message frame decoder. A short directed set of
// frames hits empty messages, over-limit counts, short frames at every header
// position, zero-payload and payload entries and trailing bytes. Random frames
// follow, mostly well formed with random content, some cut short and some
// plain noise, with random gaps and stalls on both streams. An over-limit
// frame closes the run after a full drain.
// ----------------------------------------------------------------------------
module tb_top;
   import mfd_pkg::*;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tlast;

   int          fail_count;
   int          results_owed;
   int          bytes_sent = 0;
   bit          calm_mode  = 1'b0;

   localparam int DRAIN_CYCLES  = 10;
   localparam int RANDOM_BYTES  = 1150;

   message_frame_decoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   mfd_result_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int draw_wait();
      return calm_mode ? 0 : $urandom_range(0, 4);
   endfunction

   task automatic push_frame_byte(input logic [7:0] b, input logic fend);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fend;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // hold off the sender until every queued result has been transferred
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (results_owed == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_frame(input logic [7:0] frame_bytes[$]);
      foreach (frame_bytes[i]) begin
         push_frame_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
   endtask

   task automatic push_random_frame();
      logic [7:0] body[$];
      logic [7:0] t;
      int         n_entries;
      int         r;
      int         cut;
      int         trail;
      body = {};
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
      r = $urandom_range(0, 99);
      if (r < 3) begin
         n_entries = 0;
      end else if (r < 6) begin
         n_entries = $urandom_range(ENTRY_LIMIT + 1, 255);
      end else if (r < 10) begin
         n_entries = ENTRY_LIMIT;
      end else if (r < 20) begin
         n_entries = $urandom_range(7, ENTRY_LIMIT - 1);
      end else begin
         n_entries = $urandom_range(1, 6);
      end
      body.push_back(8'(n_entries));
      if (n_entries <= ENTRY_LIMIT) begin
         for (int e = 0; e < n_entries; e++) begin
            t = 8'($urandom);
            body.push_back(t);
            if (!t[7]) begin
               repeat (4) body.push_back(8'($urandom));
            end
         end
      end
      trail = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
      repeat (trail) body.push_back(8'($urandom));
      cut = body.size() - 1;
      if ($urandom_range(0, 99) < 15) begin
         cut = $urandom_range(0, body.size() - 1);
      end
      for (int i = 0; i <= cut; i++) begin
         push_frame_byte(body[i], i == cut);
      end
   endtask

   task automatic push_noise();
      repeat ($urandom_range(1, 8)) begin
         push_frame_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   // receiver: random stall before each result transfer
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message with trailing bytes
      push_frame({8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55});
      // count over limit ending on the count byte
      push_frame({8'hFF, 8'h00, 8'd33});
      // short at id, sender and count
      push_frame({8'h12});
      push_frame({8'h34, 8'h56});
      push_frame({8'h01, 8'h02, 8'h02});
      // zero-payload entry then final payload entry ending the frame
      push_frame({8'h7E, 8'h81, 8'h02, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hA5,
                  8'h5A});
      drain_results();

      while (bytes_sent < RANDOM_BYTES + 23) begin
         if ($urandom_range(0, 9) == 0) begin
            calm_mode = !calm_mode;
         end
         if ($urandom_range(0, 99) < 8) begin
            push_noise();
         end else begin
            push_random_frame();
         end
         if ($urandom_range(0, 59) == 0) begin
            drain_results();
         end
      end
      drain_results();

      calm_mode = 1'b0;
      push_frame({8'h5C, 8'hC5, 8'd200});
      drain_results();

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
